// ----- design/isotp_reassembly_receiver_assert.svh -----
// Assertion macros used by the receiver's top-level RTL file.
`ifndef ISOTP_REASSEMBLY_RECEIVER_ASSERT_SVH
`define ISOTP_REASSEMBLY_RECEIVER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// An implication that must hold on every clock edge outside reset.
`define ISOTPRR_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("isotp receiver: implication violated");

// A condition that must never be seen outside reset.
`define ISOTPRR_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("isotp receiver: forbidden condition seen");

`else

`define ISOTPRR_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define ISOTPRR_ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

// ----- design/isotprr_pkg.sv -----
// Types, codes and constants shared by the ISO-TP reassembly receiver.
package isotprr_pkg;

    // Result kinds.
    typedef enum logic [1:0] {
        K_BYTE  = 2'd0,
        K_FC    = 2'd1,
        K_EMPTY = 2'd2,
        K_ERR   = 2'd3
    } t_kind;

    // Error codes carried by error results.
    typedef enum logic [1:0] {
        ERR_SEQ        = 2'd0,
        ERR_TIMEOUT    = 2'd1,
        ERR_UNEXPECTED = 2'd2,
        ERR_LENGTH     = 2'd3
    } t_err;

    // Receive state, one-hot.
    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RECV = 2'b10
    } t_rx_state;

    // Protocol control information, upper nibble of byte 0.
    localparam logic [3:0] PCI_SINGLE = 4'h0;
    localparam logic [3:0] PCI_FIRST  = 4'h1;
    localparam logic [3:0] PCI_CONSEC = 4'h2;

    localparam logic [2:0] CF_BYTES = 3'd7;
    localparam logic [2:0] FF_BYTES = 3'd6;

    // Configuration register indexes.
    localparam logic [2:0] REG_RECEIVE_ENABLE   = 3'd0;
    localparam logic [2:0] REG_RECEIVE_ID       = 3'd1;
    localparam logic [2:0] REG_TRANSMIT_ID      = 3'd2;
    localparam logic [2:0] REG_BLOCK_SIZE       = 3'd3;
    localparam logic [2:0] REG_SEPARATION_TIME  = 3'd4;
    localparam logic [2:0] REG_FRAME_TIMEOUT_MS = 3'd5;

    localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

    // Job queue between front and back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    // One classified input word: either a single special result or a run of
    // payload bytes optionally followed by a flow-control request.
    typedef struct packed {
        logic            special;
        t_kind           sp_kind;
        t_err            sp_err;
        logic [2:0]      n_bytes;
        logic            byte_end;
        logic            fc;
        logic [11:0]     length;
        logic [7:0][7:0] data;
    } t_job;

    // Settings the front end needs.
    typedef struct packed {
        logic        enable;
        logic [28:0] receive_id;
        logic [7:0]  block_size;
        logic [15:0] timeout;
    } t_rx_cfg;

    // Settings placed on flow-control results.
    typedef struct packed {
        logic [28:0] transmit_id;
        logic [7:0]  block_size;
        logic [7:0]  separation;
    } t_fc_cfg;

endpackage

// ----- design/isotprr_front.sv -----
// Front end: accepts frames and ticks, runs the reception state, queues jobs.
module isotprr_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic                 i_operation,
    input  logic [28:0]          i_frame_id,
    input  logic [7:0][7:0]      i_bytes,
    input  isotprr_pkg::t_rx_cfg i_cfg,
    input  logic                 i_full,
    output logic                 o_push,
    output isotprr_pkg::t_job    o_job
);

    isotprr_pkg::t_rx_state r_state, n_state;
    logic [11:0] r_total, n_total;
    logic [11:0] r_received, n_received;
    logic [3:0]  r_seq, n_seq;
    logic [7:0]  r_fib, n_fib;
    logic [15:0] r_idle, n_idle;

    logic        w_accept;
    logic        w_go_idle;
    logic [15:0] w_idle_inc;
    logic [3:0]  w_pci;
    logic [3:0]  w_nib;
    logic [11:0] w_ff_total;
    logic [11:0] w_remaining;
    logic [2:0]  w_take;
    logic [11:0] w_received_inc;
    logic [7:0]  w_fib_inc;

    assign o_ready  = !i_full;
    assign w_accept = i_valid && o_ready;

    assign w_pci          = i_bytes[0][7:4];
    assign w_nib          = i_bytes[0][3:0];
    assign w_ff_total     = {w_nib, i_bytes[1]};
    assign w_idle_inc     = (r_idle == 16'hFFFF) ? r_idle : r_idle + 16'd1;
    assign w_remaining    = r_total - r_received;
    assign w_take         = (w_remaining > {9'd0, isotprr_pkg::CF_BYTES})
                            ? isotprr_pkg::CF_BYTES : w_remaining[2:0];
    assign w_received_inc = r_received + {9'd0, w_take};
    assign w_fib_inc      = r_fib + 8'd1;

    // Classify the word and work out the next reception state.
    always_comb begin
        n_state    = r_state;
        n_total    = r_total;
        n_received = r_received;
        n_seq      = r_seq;
        n_fib      = r_fib;
        n_idle     = r_idle;
        w_go_idle  = 1'b0;
        o_push     = 1'b0;
        o_job      = '0;
        if (w_accept) begin
            if (i_operation) begin
                // Tick: supervise the time between consecutive frames.
                if (r_state == isotprr_pkg::ST_RECV) begin
                    n_idle = w_idle_inc;
                    if (w_idle_inc >= i_cfg.timeout) begin
                        o_push        = 1'b1;
                        o_job.special = 1'b1;
                        o_job.sp_kind = isotprr_pkg::K_ERR;
                        o_job.sp_err  = isotprr_pkg::ERR_TIMEOUT;
                        o_job.length  = r_total;
                        w_go_idle     = 1'b1;
                    end
                end
            end else if (i_cfg.enable && (i_frame_id == i_cfg.receive_id)) begin
                unique case (r_state)
                    isotprr_pkg::ST_IDLE: begin
                        if (w_pci == isotprr_pkg::PCI_SINGLE) begin
                            o_push = 1'b1;
                            if (w_nib == 4'd0) begin
                                o_job.special = 1'b1;
                                o_job.sp_kind = isotprr_pkg::K_EMPTY;
                            end else if (w_nib > {1'b0, isotprr_pkg::CF_BYTES}) begin
                                o_job.special = 1'b1;
                                o_job.sp_kind = isotprr_pkg::K_ERR;
                                o_job.sp_err  = isotprr_pkg::ERR_LENGTH;
                                o_job.length  = {8'd0, w_nib};
                            end else begin
                                o_job.n_bytes  = w_nib[2:0];
                                o_job.byte_end = 1'b1;
                                o_job.length   = {8'd0, w_nib};
                                o_job.data     = {8'd0, i_bytes[7:1]};
                            end
                        end else if (w_pci == isotprr_pkg::PCI_FIRST) begin
                            o_push = 1'b1;
                            if (w_ff_total < 12'd8) begin
                                o_job.special = 1'b1;
                                o_job.sp_kind = isotprr_pkg::K_ERR;
                                o_job.sp_err  = isotprr_pkg::ERR_LENGTH;
                                o_job.length  = w_ff_total;
                            end else begin
                                o_job.n_bytes = isotprr_pkg::FF_BYTES;
                                o_job.fc      = 1'b1;
                                o_job.length  = w_ff_total;
                                o_job.data    = {16'd0, i_bytes[7:2]};
                                n_state       = isotprr_pkg::ST_RECV;
                                n_total       = w_ff_total;
                                n_received    = {9'd0, isotprr_pkg::FF_BYTES};
                                n_seq         = 4'd1;
                                n_fib         = 8'd0;
                                n_idle        = 16'd0;
                            end
                        end else begin
                            o_push        = 1'b1;
                            o_job.special = 1'b1;
                            o_job.sp_kind = isotprr_pkg::K_ERR;
                            o_job.sp_err  = isotprr_pkg::ERR_UNEXPECTED;
                        end
                    end
                    isotprr_pkg::ST_RECV: begin
                        // Anything but a consecutive frame is ignored here.
                        if (w_pci == isotprr_pkg::PCI_CONSEC) begin
                            o_push = 1'b1;
                            if (w_nib != r_seq) begin
                                o_job.special = 1'b1;
                                o_job.sp_kind = isotprr_pkg::K_ERR;
                                o_job.sp_err  = isotprr_pkg::ERR_SEQ;
                                o_job.length  = r_total;
                                w_go_idle     = 1'b1;
                            end else begin
                                o_job.n_bytes  = w_take;
                                o_job.byte_end = (w_received_inc >= r_total);
                                o_job.length   = r_total;
                                o_job.data     = {8'd0, i_bytes[7:1]};
                                n_seq          = r_seq + 4'd1;
                                n_received     = w_received_inc;
                                n_fib          = w_fib_inc;
                                n_idle         = 16'd0;
                                if (w_received_inc >= r_total) begin
                                    w_go_idle = 1'b1;
                                end else if ((i_cfg.block_size != 8'd0) &&
                                             (w_fib_inc >= i_cfg.block_size)) begin
                                    n_fib    = 8'd0;
                                    o_job.fc = 1'b1;
                                end
                            end
                        end
                    end
                    default: begin
                        w_go_idle = 1'b1;
                    end
                endcase
            end
        end
        // Return to idle with a clean reception context.
        if (w_go_idle) begin
            n_state    = isotprr_pkg::ST_IDLE;
            n_total    = 12'd0;
            n_received = 12'd0;
            n_seq      = 4'd1;
            n_fib      = 8'd0;
            n_idle     = 16'd0;
        end
    end

    // Reception state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= isotprr_pkg::ST_IDLE;
            r_total    <= 12'd0;
            r_received <= 12'd0;
            r_seq      <= 4'd1;
            r_fib      <= 8'd0;
            r_idle     <= 16'd0;
        end else begin
            r_state    <= n_state;
            r_total    <= n_total;
            r_received <= n_received;
            r_seq      <= n_seq;
            r_fib      <= n_fib;
            r_idle     <= n_idle;
        end
    end

endmodule

// ----- design/isotprr_queue.sv -----
// Short job queue that decouples the front end from the result sequencer.
module isotprr_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  isotprr_pkg::t_job i_job,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_empty,
    output isotprr_pkg::t_job o_job
);

    isotprr_pkg::t_job r_mem [isotprr_pkg::QUEUE_DEPTH];
    logic [isotprr_pkg::QUEUE_AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [isotprr_pkg::QUEUE_AW:0]   r_count;

    assign o_full  = (r_count == (isotprr_pkg::QUEUE_AW + 1)'(isotprr_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rd_ptr];

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ----- design/isotprr_back.sv -----
// Back end: expands queued jobs into result words, one per cycle while the output is not held by i_ready.
module isotprr_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_empty,
    input  isotprr_pkg::t_job    i_job,
    output logic                 o_pop,
    input  isotprr_pkg::t_fc_cfg i_cfg,
    output logic                 o_valid,
    input  logic                 i_ready,
    output isotprr_pkg::t_kind   o_kind,
    output logic [7:0]           o_payload_byte,
    output logic                 o_last,
    output logic                 o_message_end,
    output logic [11:0]          o_message_length,
    output isotprr_pkg::t_err    o_error_code,
    output logic [28:0]          o_fc_id,
    output logic [7:0]           o_fc_block_size,
    output logic [7:0]           o_fc_separation
);

    logic [2:0] r_idx;
    logic       r_valid;

    logic                 w_load;
    logic                 w_final;
    logic                 w_is_byte;
    logic                 w_last_byte;
    isotprr_pkg::t_kind   w_kind;
    logic [7:0]           w_byte;
    logic                 w_end;
    isotprr_pkg::t_err    w_err;

    assign w_load      = !i_empty && (!r_valid || i_ready);
    assign w_is_byte   = !i_job.special && (r_idx < i_job.n_bytes);
    assign w_last_byte = (r_idx == i_job.n_bytes - 3'd1);
    assign o_pop       = w_load && w_final;
    assign o_valid     = r_valid;

    // Select the result at the current position of the head job.
    always_comb begin
        w_kind  = isotprr_pkg::K_FC;
        w_byte  = 8'd0;
        w_end   = 1'b0;
        w_err   = isotprr_pkg::ERR_SEQ;  // zero on non-error results
        w_final = 1'b1;
        if (i_job.special) begin
            w_kind = i_job.sp_kind;
            w_err  = i_job.sp_err;
        end else if (w_is_byte) begin
            w_kind  = isotprr_pkg::K_BYTE;
            w_byte  = i_job.data[r_idx];
            w_end   = i_job.byte_end && w_last_byte;
            w_final = w_last_byte && !i_job.fc;
        end
    end

    // Position within the head job.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= 3'd0;
            r_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_idx <= w_final ? 3'd0 : r_idx + 3'd1;
            end
            if (w_load) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Output word register.
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            o_kind           <= w_kind;
            o_payload_byte   <= w_byte;
            o_last           <= w_final;
            o_message_end    <= w_end;
            o_message_length <= i_job.length;
            o_error_code     <= w_err;
            if (w_kind == isotprr_pkg::K_FC) begin
                o_fc_id         <= i_cfg.transmit_id;
                o_fc_block_size <= i_cfg.block_size;
                o_fc_separation <= i_cfg.separation;
            end else begin
                o_fc_id         <= 29'd0;
                o_fc_block_size <= 8'd0;
                o_fc_separation <= 8'd0;
            end
        end
    end

endmodule

// ----- design/isotp_reassembly_receiver.sv -----
// Top level of the ISO-TP reassembly receiver.
//
// Input channel (i_valid/o_ready) takes one word per cycle: a received CAN
// frame (i_operation 0) or a one-millisecond tick (i_operation 1). The output
// channel (o_valid/i_ready) delivers result words: payload bytes, flow-control
// requests, empty-message marks and errors; o_last flags the final result of
// an input word. A frame produces up to eight results, a tick at most one.
// The front end classifies a word in the cycle it is accepted and queues a
// job, whose first result the back end then registers. The sequencer emits
// one result per cycle while i_ready is high, and a four-entry job queue lets
// up to four frames arrive one per cycle while earlier results drain. When
// i_ready is low the output word is held and the queue fills; o_ready drops
// only when the queue is full. Configuration writes (i_cfg_wr_en,
// i_cfg_index, i_cfg_data) take effect at the next edge. Reset is
// synchronous: reception goes idle, the queue and the output empty, and
// registers return to enable on, identifiers zero, block size zero,
// separation zero and a 1000 tick frame timeout.
module isotp_reassembly_receiver (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_operation,
    input  logic [28:0] i_frame_id,
    input  logic [7:0]  i_byte0,
    input  logic [7:0]  i_byte1,
    input  logic [7:0]  i_byte2,
    input  logic [7:0]  i_byte3,
    input  logic [7:0]  i_byte4,
    input  logic [7:0]  i_byte5,
    input  logic [7:0]  i_byte6,
    input  logic [7:0]  i_byte7,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_payload_byte,
    output logic        o_last,
    output logic        o_message_end,
    output logic [11:0] o_message_length,
    output logic [1:0]  o_error_code,
    output logic [28:0] o_fc_id,
    output logic [7:0]  o_fc_block_size,
    output logic [7:0]  o_fc_separation,
    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_index,
    input  logic [28:0] i_cfg_data
);

`include "isotp_reassembly_receiver_assert.svh"

    logic        r_enable;
    logic [28:0] r_receive_id;
    logic [28:0] r_transmit_id;
    logic [7:0]  r_block_size;
    logic [7:0]  r_separation;
    logic [15:0] r_timeout;

    isotprr_pkg::t_rx_cfg w_rx_cfg;
    isotprr_pkg::t_fc_cfg w_fc_cfg;
    isotprr_pkg::t_job    w_push_job;
    isotprr_pkg::t_job    w_head_job;
    isotprr_pkg::t_kind   w_kind;
    isotprr_pkg::t_err    w_err;
    logic                 w_push;
    logic                 w_pop;
    logic                 w_full;
    logic                 w_empty;
    logic [7:0][7:0]      w_bytes;

    assign w_bytes  = {i_byte7, i_byte6, i_byte5, i_byte4,
                       i_byte3, i_byte2, i_byte1, i_byte0};
    assign w_rx_cfg = '{enable: r_enable, receive_id: r_receive_id,
                        block_size: r_block_size, timeout: r_timeout};
    assign w_fc_cfg = '{transmit_id: r_transmit_id, block_size: r_block_size,
                        separation: r_separation};
    assign o_kind       = w_kind;
    assign o_error_code = w_err;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable      <= 1'b1;
            r_receive_id  <= 29'd0;
            r_transmit_id <= 29'd0;
            r_block_size  <= 8'd0;
            r_separation  <= 8'd0;
            r_timeout     <= isotprr_pkg::TIMEOUT_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                isotprr_pkg::REG_RECEIVE_ENABLE:   r_enable      <= i_cfg_data[0];
                isotprr_pkg::REG_RECEIVE_ID:       r_receive_id  <= i_cfg_data;
                isotprr_pkg::REG_TRANSMIT_ID:      r_transmit_id <= i_cfg_data;
                isotprr_pkg::REG_BLOCK_SIZE:       r_block_size  <= i_cfg_data[7:0];
                isotprr_pkg::REG_SEPARATION_TIME:  r_separation  <= i_cfg_data[7:0];
                isotprr_pkg::REG_FRAME_TIMEOUT_MS: r_timeout     <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    // Front end: classification and reception state.
    isotprr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_operation (i_operation),
        .i_frame_id  (i_frame_id),
        .i_bytes     (w_bytes),
        .i_cfg       (w_rx_cfg),
        .i_full      (w_full),
        .o_push      (w_push),
        .o_job       (w_push_job)
    );

    // Job queue.
    isotprr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_job   (w_head_job)
    );

    // Back end: result sequencer and output register.
    isotprr_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_empty          (w_empty),
        .i_job            (w_head_job),
        .o_pop            (w_pop),
        .i_cfg            (w_fc_cfg),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_kind           (w_kind),
        .o_payload_byte   (o_payload_byte),
        .o_last           (o_last),
        .o_message_end    (o_message_end),
        .o_message_length (o_message_length),
        .o_error_code     (w_err),
        .o_fc_id          (o_fc_id),
        .o_fc_block_size  (o_fc_block_size),
        .o_fc_separation  (o_fc_separation)
    );

    // The front end never queues a job into a full queue.
    `ISOTPRR_ASSERT_NEVER(a_no_overflow, i_clk, i_rst_n, w_push && w_full)
    // The sequencer never pops an empty queue.
    `ISOTPRR_ASSERT_NEVER(a_no_underflow, i_clk, i_rst_n, w_pop && w_empty)
    // The final byte of a message always closes its input word.
    `ISOTPRR_ASSERT_IMPLIES(a_end_is_last, i_clk, i_rst_n,
        o_valid && o_message_end, o_last && (w_kind == isotprr_pkg::K_BYTE))
    // An error is always the only result of its input word.
    `ISOTPRR_ASSERT_IMPLIES(a_err_is_last, i_clk, i_rst_n,
        o_valid && (w_kind == isotprr_pkg::K_ERR), o_last)

endmodule
